// ===== src/bra_pkg.sv =====
package bra_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int REG_COUNT = 3;

    typedef logic [BYTE_W-1:0] t_byte;

    // Instruction codes
    localparam logic [3:0] OP_MOV_REG  = 4'd0;
    localparam logic [3:0] OP_MOV_IMM  = 4'd1;
    localparam logic [3:0] OP_OR       = 4'd2;
    localparam logic [3:0] OP_XOR      = 4'd3;
    localparam logic [3:0] OP_AND      = 4'd4;
    localparam logic [3:0] OP_ADD      = 4'd5;
    localparam logic [3:0] OP_SUB      = 4'd6;
    localparam logic [3:0] OP_MUL      = 4'd7;
    localparam logic [3:0] OP_DIV      = 4'd8;
    localparam logic [3:0] OP_CMP      = 4'd9;
    localparam logic [3:0] OP_PUSH_REG = 4'd10;
    localparam logic [3:0] OP_PUSH_IMM = 4'd11;
    localparam logic [3:0] OP_POP      = 4'd12;

    // Register selectors
    localparam logic [1:0] REG_AL   = 2'd0;
    localparam logic [1:0] REG_BL   = 2'd1;
    localparam logic [1:0] REG_CL   = 2'd2;
    // Selector that names no register
    localparam logic [1:0] REG_NONE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    localparam logic [2:0] DIV_LAST = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ===== src/bra_ram.sv =====
module bra_ram
    import bra_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/byte_register_alu_with_stack.sv =====
// Byte register ALU with a bounded byte stack. Each input transaction carries
// one decoded instruction that acts on three 8-bit registers (AL, BL, CL), an
// equal flag and a stack of up to STACK_DEPTH bytes; each one returns exactly
// one result transaction with a status code, all three registers, the flag and
// the stack depth as they stand after the instruction. Arithmetic wraps modulo
// 256 and divide is unsigned. A zero divisor, a push onto a full stack and a
// pop from an empty stack are flagged in the status and change nothing; a
// register selector of 3 names no register; an instruction that uses it is a no-op.
// One instruction is in flight at a time. Most instructions go from acceptance
// to result valid through accept, execute and a load of the result register;
// divide adds the restoring divider after execute, one quotient bit per cycle.
// The stack bytes live in a synchronous RAM whose registered read is issued at
// acceptance, so a pop reads its byte in the execute cycle. A new instruction
// may be accepted while the previous result still waits to be taken; its
// result is then held back until the result register is free.
module byte_register_alu_with_stack
    import bra_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Instruction channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [3:0]          i_req_type,
    input  logic [1:0]          i_dst_reg,
    input  logic [1:0]          i_src_reg,
    input  logic [7:0]          i_immediate,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [7:0]          o_reg_al,
    output logic [7:0]          o_reg_bl,
    output logic [7:0]          o_reg_cl,
    output logic                o_equal_out,
    output logic [COUNT_W-1:0]  o_stack_count
);

    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    t_state r_state, n_state;

    // Captured instruction
    logic [3:0] r_req_type;
    logic [1:0] r_dst_reg;
    logic [1:0] r_src_reg;
    t_byte      r_immediate;

    // Architectural state held in flops; stack bytes in the RAM
    t_byte          r_regs [REG_COUNT];
    t_byte          n_regs [REG_COUNT];
    logic           r_equal, n_equal;
    logic [PW-1:0]  r_sp, n_sp;
    logic [1:0]     r_status, n_status;

    // Divider
    t_byte          r_rem, n_rem;
    t_byte          r_quo, n_quo;
    t_byte          r_dvs, n_dvs;
    logic [2:0]     r_div_cnt, n_div_cnt;

    // Result register
    logic           r_out_valid;
    logic [1:0]     r_out_status;
    t_byte          r_out_al, r_out_bl, r_out_cl;
    logic           r_out_equal;
    logic [COUNT_W-1:0] r_out_count;

    // RAM port
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    t_byte          ram_wdata;
    logic [AW-1:0]  ram_raddr;
    t_byte          ram_rdata;

    // Register write request from the execute and divide steps
    logic           wr_en;
    logic [1:0]     wr_sel;
    t_byte          wr_data;

    t_byte          opa, opb;
    logic           dst_ok, src_ok, stack_full, stack_empty;
    logic           div_go, out_load;
    logic [8:0]     div_shift;
    logic [8:0]     div_trial;
    logic [15:0]    product;

    bra_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Operand selection; selector 3 reads as zero and is caught by dst_ok/src_ok
    always_comb begin
        case (r_dst_reg)
            REG_AL:  opa = r_regs[0];
            REG_BL:  opa = r_regs[1];
            REG_CL:  opa = r_regs[2];
            default: opa = '0;
        endcase
        case (r_src_reg)
            REG_AL:  opb = r_regs[0];
            REG_BL:  opb = r_regs[1];
            REG_CL:  opb = r_regs[2];
            default: opb = '0;
        endcase
    end

    assign dst_ok      = (r_dst_reg != REG_NONE);
    assign src_ok      = (r_src_reg != REG_NONE);
    assign stack_full  = (r_sp == PW'(STACK_DEPTH));
    assign stack_empty = (r_sp == '0);
    assign product     = 16'(opa) * 16'(opb);
    assign div_go      = (r_req_type == OP_DIV) && dst_ok && src_ok && (opb != '0);

    // Restoring divide step: shift in the next dividend bit, subtract if it fits
    assign div_shift = {r_rem, r_quo[BYTE_W-1]};
    assign div_trial = div_shift - {1'b0, r_dvs};

    // Issue the pop read as the instruction is accepted; it lands in S_EXEC
    assign ram_raddr = AW'(r_sp - PW'(1));
    assign ram_waddr = AW'(r_sp);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = div_go ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    // Datapath: execute, divide iterations
    always_comb begin
        n_equal   = r_equal;
        n_sp      = r_sp;
        n_status  = r_status;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dvs     = r_dvs;
        n_div_cnt = r_div_cnt;
        wr_en     = 1'b0;
        wr_sel    = r_dst_reg;
        wr_data   = opa;
        ram_we    = 1'b0;
        ram_wdata = r_immediate;

        case (r_state)
            S_EXEC: begin
                n_status = ST_OK;
                case (r_req_type)
                    OP_MOV_IMM: begin
                        wr_en   = dst_ok;
                        wr_data = r_immediate;
                    end
                    OP_MOV_REG, OP_OR, OP_XOR, OP_AND, OP_ADD, OP_SUB, OP_MUL: begin
                        wr_en = dst_ok && src_ok;
                        case (r_req_type)
                            OP_MOV_REG: wr_data = opb;
                            OP_OR:      wr_data = opa | opb;
                            OP_XOR:     wr_data = opa ^ opb;
                            OP_AND:     wr_data = opa & opb;
                            OP_ADD:     wr_data = opa + opb;
                            OP_SUB:     wr_data = opa - opb;
                            default:    wr_data = product[BYTE_W-1:0];
                        endcase
                    end
                    OP_DIV: begin
                        if (dst_ok && src_ok) begin
                            if (opb == '0) begin
                                n_status = ST_DIVZERO;
                            end
                            n_rem     = '0;
                            n_quo     = opa;
                            n_dvs     = opb;
                            n_div_cnt = '0;
                        end
                    end
                    OP_CMP: begin
                        if (dst_ok && src_ok) begin
                            n_equal = (opa == opb);
                        end
                    end
                    OP_PUSH_REG: begin
                        if (dst_ok) begin
                            if (stack_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = opa;
                                n_sp      = r_sp + PW'(1);
                                wr_en     = 1'b1;
                                wr_data   = '0;
                            end
                        end
                    end
                    OP_PUSH_IMM: begin
                        if (stack_full) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we = 1'b1;
                            n_sp   = r_sp + PW'(1);
                        end
                    end
                    OP_POP: begin
                        if (stack_empty) begin
                            n_status = ST_EMPTY;
                        end else if (dst_ok) begin
                            n_sp    = r_sp - PW'(1);
                            wr_en   = 1'b1;
                            wr_data = ram_rdata;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV: begin
                if (div_shift >= {1'b0, r_dvs}) begin
                    n_rem = div_trial[BYTE_W-1:0];
                    n_quo = {r_quo[BYTE_W-2:0], 1'b1};
                end else begin
                    n_rem = div_shift[BYTE_W-1:0];
                    n_quo = {r_quo[BYTE_W-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt + 3'd1;
                if (r_div_cnt == DIV_LAST) begin
                    wr_en   = 1'b1;
                    wr_data = n_quo;
                end
            end
            default: ;
        endcase

        for (int i = 0; i < REG_COUNT; i++) begin
            n_regs[i] = (wr_en && wr_sel == 2'(i)) ? wr_data : r_regs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_equal     <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_equal <= n_equal;
            r_sp    <= n_sp;
            r_regs  <= n_regs;
            // Hold the result until taken; reload from the committed state
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type  <= i_req_type;
            r_dst_reg   <= i_dst_reg;
            r_src_reg   <= i_src_reg;
            r_immediate <= i_immediate;
        end
        r_status  <= n_status;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvs     <= n_dvs;
        r_div_cnt <= n_div_cnt;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_al     <= r_regs[0];
            r_out_bl     <= r_regs[1];
            r_out_cl     <= r_regs[2];
            r_out_equal  <= r_equal;
            r_out_count  <= COUNT_W'(r_sp);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_reg_al      = r_out_al;
    assign o_reg_bl      = r_out_bl;
    assign o_reg_cl      = r_out_cl;
    assign o_equal_out   = r_out_equal;
    assign o_stack_count = r_out_count;

endmodule

// ===== src/bra_checker.sv =====
module bra_checker
    import bra_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_status,
    input logic [7:0]         o_reg_al,
    input logic [7:0]         o_reg_bl,
    input logic [7:0]         o_reg_cl,
    input logic               o_equal_out,
    input logic [COUNT_W-1:0] o_stack_count
);

    // Hold a stalled result steady
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
            $stable({o_status, o_reg_al, o_reg_bl, o_reg_cl, o_equal_out, o_stack_count}))
        else $error("stalled result changed");

    // One instruction in flight: drop ready after every accepted transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an accepted transaction");

    // An empty-stack status can only come with an empty stack
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_stack_count == '0)
        else $error("empty-stack status with non-zero depth");

    // A result is never announced straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind byte_register_alu_with_stack bra_checker u_bra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_reg_al      (o_reg_al),
    .o_reg_bl      (o_reg_bl),
    .o_reg_cl      (o_reg_cl),
    .o_equal_out   (o_equal_out),
    .o_stack_count (o_stack_count)
);

// ===== dv/byte_register_alu_with_stack_tb.sv =====
`timescale 1ns / 1ps

module byte_register_alu_with_stack_tb;
    import bra_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int TARGET_ITEMS = 450;
    localparam int MAX_GAP = 6;
    // Result count at which the receiver stops taking results for a long stretch
    localparam int STALL_AT = 150;
    localparam int LONG_STALL = 250;
    // Divide is the slowest instruction; allow a margin on top
    localparam int DRAIN_CYCLES = 24;
    localparam int TIMEOUT_NS = 2_000_000;

    // Codes the block treats as no-ops
    localparam logic [3:0] OP_SPARE_FIRST = OP_POP + 4'd1;
    localparam logic [3:0] OP_SPARE_LAST = 4'hF;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] dst;
        logic [1:0] src;
        t_byte      imm;
        logic       hold;   // wait until every outstanding result has arrived
    } t_instr;

    typedef struct packed {
        logic [1:0]         status;
        t_byte              al;
        t_byte              bl;
        t_byte              cl;
        logic               eq;
        logic [COUNT_W-1:0] depth;
    } t_result;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [3:0]         i_req_type = OP_MOV_REG;
    logic [1:0]         i_dst_reg = REG_AL;
    logic [1:0]         i_src_reg = REG_AL;
    logic [7:0]         i_immediate = 8'h00;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic [7:0]         o_reg_al;
    logic [7:0]         o_reg_bl;
    logic [7:0]         o_reg_cl;
    logic               o_equal_out;
    logic [COUNT_W-1:0] o_stack_count;

    byte_register_alu_with_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_dst_reg     (i_dst_reg),
        .i_src_reg     (i_src_reg),
        .i_immediate   (i_immediate),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_reg_al      (o_reg_al),
        .o_reg_bl      (o_reg_bl),
        .o_reg_cl      (o_reg_cl),
        .o_equal_out   (o_equal_out),
        .o_stack_count (o_stack_count)
    );

    // Shadow of the architectural state, advanced once per accepted instruction
    t_byte   regfile [REG_COUNT] = '{default: '0};
    logic    eq_flag = 1'b0;
    t_byte   stack_mem [STACK_DEPTH];
    int      stack_ptr = 0;

    t_instr  instr_queue [$];
    t_result predicted_results [$];
    t_instr  cur_instr;
    logic    hold_next = 1'b0;

    int      n_sent = 0;
    int      n_got = 0;
    int      errors = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      stall_left = 0;
    int      status_tally [4] = '{default: 0};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one instruction to the shadow state and return the state it leaves behind.
    function automatic t_result execute_instr(t_instr ins);
        t_result    res;
        logic [1:0] st;
        logic       dst_ok;
        logic       src_ok;
        t_byte      a;
        t_byte      b;
        t_byte      v;
        st = ST_OK;
        dst_ok = (ins.dst != REG_NONE);
        src_ok = (ins.src != REG_NONE);
        case (ins.op)
            OP_MOV_IMM: begin
                if (dst_ok) regfile[ins.dst] = ins.imm;
            end
            OP_MOV_REG, OP_OR, OP_XOR, OP_AND, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
            OP_CMP: begin
                if (dst_ok && src_ok) begin
                    a = regfile[ins.dst];
                    b = regfile[ins.src];
                    v = a;
                    case (ins.op)
                        OP_MOV_REG: v = b;
                        OP_OR:      v = a | b;
                        OP_XOR:     v = a ^ b;
                        OP_AND:     v = a & b;
                        OP_ADD:     v = a + b;
                        OP_SUB:     v = a - b;
                        OP_MUL:     v = a * b;
                        OP_DIV: begin
                            // zero divisor leaves the destination alone
                            if (b == '0) st = ST_DIVZERO;
                            else v = a / b;
                        end
                        default:    eq_flag = (a == b);
                    endcase
                    regfile[ins.dst] = v;
                end
            end
            OP_PUSH_REG: begin
                if (dst_ok) begin
                    if (stack_ptr >= STACK_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        stack_mem[stack_ptr] = regfile[ins.dst];
                        stack_ptr++;
                        regfile[ins.dst] = '0;
                    end
                end
            end
            OP_PUSH_IMM: begin
                if (stack_ptr >= STACK_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    stack_mem[stack_ptr] = ins.imm;
                    stack_ptr++;
                end
            end
            OP_POP: begin
                // empty check wins over a missing destination register
                if (stack_ptr == 0) begin
                    st = ST_EMPTY;
                end else if (dst_ok) begin
                    stack_ptr--;
                    regfile[ins.dst] = stack_mem[stack_ptr];
                end
            end
            default: ;
        endcase
        res.status = st;
        res.al = regfile[REG_AL];
        res.bl = regfile[REG_BL];
        res.cl = regfile[REG_CL];
        res.eq = eq_flag;
        res.depth = COUNT_W'(stack_ptr);
        return res;
    endfunction

    function automatic logic [1:0] pick_reg();
        if ($urandom_range(0, 11) == 0) return REG_NONE;
        return 2'($urandom_range(REG_AL, REG_CL));
    endfunction

    function automatic t_byte pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_instr(logic [3:0] op, logic [1:0] dst, logic [1:0] src, t_byte imm);
        t_instr ins;
        ins.op = op;
        ins.dst = dst;
        ins.src = src;
        ins.imm = imm;
        ins.hold = hold_next;
        hold_next = 1'b0;
        instr_queue.insert(instr_queue.size(), ins);
    endtask

    // Sender: offer the next pending instruction after its drawn gap; hold the
    // payload steady while the block is not ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_results.insert(predicted_results.size(), execute_instr(cur_instr));
                n_sent++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold: transaction still pending
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (instr_queue.size() > 0 &&
                         (!instr_queue[0].hold || predicted_results.size() == 0)) begin
                cur_instr = instr_queue.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= cur_instr.op;
                i_dst_reg <= cur_instr.dst;
                i_src_reg <= cur_instr.src;
                i_immediate <= cur_instr.imm;
                // every fourth window of 50 instructions runs back to back
                send_gap = ((n_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result transaction against the oldest prediction,
    // then back-pressure for a drawn number of cycles.
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_res;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got.status = o_status;
                got.al = o_reg_al;
                got.bl = o_reg_bl;
                got.cl = o_reg_cl;
                got.eq = o_equal_out;
                got.depth = o_stack_count;
                if (predicted_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result status=%0d al=%02h bl=%02h",
                             $time, got.status, got.al, got.bl,
                             " cl=%02h eq=%0b depth=%0d", got.cl, got.eq, got.depth);
                end else begin
                    exp_res = predicted_results.pop_front();
                    if (got !== exp_res) begin
                        errors++;
                        $display("%0t: result %0d expected status=%0d al=%02h bl=%02h",
                                 $time, n_got, exp_res.status, exp_res.al, exp_res.bl,
                                 " cl=%02h eq=%0b depth=%0d",
                                 exp_res.cl, exp_res.eq, exp_res.depth);
                        $display("%0t: result %0d actual   status=%0d al=%02h bl=%02h",
                                 $time, n_got, got.status, got.al, got.bl,
                                 " cl=%02h eq=%0b depth=%0d", got.cl, got.eq, got.depth);
                    end
                end
                status_tally[got.status]++;
                n_got++;
                recv_gap = ((n_got / 50) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
                // stop taking results for a long stretch so the block backs up
                if (n_got == STALL_AT) stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int  n;
        logic pause_a_done;
        logic pause_b_done;
        pause_a_done = 1'b0;
        pause_b_done = 1'b0;

        // Directed opening: empty pop, operand extremes, every operation and the
        // no-op cases (missing register selector, spare opcodes).
        queue_instr(OP_POP,      REG_AL,   REG_AL,   8'h00);
        queue_instr(OP_MOV_IMM,  REG_AL,   REG_AL,   8'hFF);
        queue_instr(OP_MOV_IMM,  REG_BL,   REG_AL,   8'h00);
        queue_instr(OP_DIV,      REG_AL,   REG_BL,   8'h00);
        queue_instr(OP_MOV_IMM,  REG_BL,   REG_AL,   8'h10);
        queue_instr(OP_ADD,      REG_AL,   REG_BL,   8'h00);
        queue_instr(OP_SUB,      REG_CL,   REG_AL,   8'h00);
        queue_instr(OP_MUL,      REG_CL,   REG_AL,   8'h00);
        queue_instr(OP_OR,       REG_AL,   REG_BL,   8'h00);
        queue_instr(OP_XOR,      REG_CL,   REG_AL,   8'hAA);
        queue_instr(OP_AND,      REG_BL,   REG_CL,   8'h55);
        queue_instr(OP_DIV,      REG_CL,   REG_BL,   8'h00);
        queue_instr(OP_CMP,      REG_AL,   REG_AL,   8'h00);
        queue_instr(OP_CMP,      REG_AL,   REG_BL,   8'h00);
        queue_instr(OP_MOV_REG,  REG_CL,   REG_AL,   8'h00);
        queue_instr(OP_PUSH_REG, REG_AL,   REG_AL,   8'h00);
        queue_instr(OP_PUSH_IMM, REG_AL,   REG_AL,   8'hAA);
        queue_instr(OP_POP,      REG_BL,   REG_AL,   8'h00);
        queue_instr(OP_POP,      REG_NONE, REG_AL,   8'h00);
        queue_instr(OP_ADD,      REG_NONE, REG_BL,   8'h00);
        queue_instr(OP_MOV_IMM,  REG_BL,   REG_AL,   8'h00);
        queue_instr(OP_DIV,      REG_CL,   REG_NONE, 8'h00);
        queue_instr(OP_PUSH_REG, REG_NONE, REG_AL,   8'h00);
        queue_instr(OP_SPARE_FIRST, REG_AL, REG_BL,  8'hFF);
        queue_instr(OP_SPARE_LAST,  REG_CL, REG_CL,  8'h55);
        queue_instr(OP_MOV_IMM,  REG_NONE, REG_NONE, 8'hFF);

        // Random part: mostly well-formed sequences (load then operate, deep
        // push and pop bursts that reach both full and empty), some noise.
        while (instr_queue.size() < TARGET_ITEMS) begin
            // hold the sender twice until everything in flight has drained
            if (!pause_a_done && instr_queue.size() > 150) begin
                hold_next = 1'b1;
                pause_a_done = 1'b1;
            end
            if (!pause_b_done && instr_queue.size() > 330) begin
                hold_next = 1'b1;
                pause_b_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    n = $urandom_range(0, 2);
                    repeat (n) queue_instr(OP_MOV_IMM, pick_reg(), REG_AL, pick_byte());
                    n = $urandom_range(1, 3);
                    repeat (n) queue_instr(4'($urandom_range(OP_MOV_REG, OP_CMP)),
                                           pick_reg(), pick_reg(), pick_byte());
                end
                5, 6: begin
                    n = $urandom_range(1, STACK_DEPTH + 2);
                    repeat (n) begin
                        if ($urandom_range(0, 1) == 0)
                            queue_instr(OP_PUSH_IMM, pick_reg(), pick_reg(), pick_byte());
                        else
                            queue_instr(OP_PUSH_REG, pick_reg(), pick_reg(), pick_byte());
                    end
                end
                7: begin
                    n = $urandom_range(1, STACK_DEPTH + 2);
                    repeat (n) queue_instr(OP_POP, pick_reg(), pick_reg(), pick_byte());
                end
                8: begin
                    n = $urandom_range(1, 6);
                    repeat (n) queue_instr($urandom_range(0, 1) ? OP_POP : OP_PUSH_IMM,
                                           pick_reg(), pick_reg(), pick_byte());
                end
                default: begin
                    queue_instr(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                                2'($urandom_range(0, 3)), t_byte'($urandom_range(0, 255)));
                end
            endcase
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_queue.size() != 0 || i_in_valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (predicted_results.size() != 0) begin
            errors += predicted_results.size();
            $display("%0t: %0d predicted results never arrived", $time,
                     predicted_results.size());
        end
        $display("Ran %0d instructions: %0d ok, %0d empty-stack pops,",
                 n_sent, status_tally[ST_OK], status_tally[ST_EMPTY],
                 " %0d full-stack pushes, %0d zero divisors",
                 status_tally[ST_FULL], status_tally[ST_DIVZERO]);
        $display("Included a %0d-cycle result stall and two drain pauses on the input side",
                 LONG_STALL);
        if (errors == 0)
            $display("byte_register_alu_with_stack_tb: clean");
        else
            $display("byte_register_alu_with_stack_tb: errors");
        $finish;
    end

    // Watchdog: a correct run finishes far inside this
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, predicted_results.size());
        $display("byte_register_alu_with_stack_tb: errors");
        $finish;
    end

endmodule
